/* rtl/core/ggh_pkg.sv */
// Shared types, constants and the arctangent table of the go-to-goal controller.
// No dependencies; every file of the block refers to it by scoped names.
package ggh_pkg;

  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int POS_FRAC_BITS_DEF = 8;
  localparam int TABLE_LEN         = 24;
  localparam int CW                = 52;
  localparam int ZW                = 33;
  localparam int ROOT_STEPS        = 25;

  localparam logic signed [17:0] DEG180     = 18'sd11520;
  localparam logic signed [17:0] DEG90      = 18'sd5760;
  localparam logic signed [17:0] TURN_LIMIT = 18'sd23040;
  localparam logic [32:0]        SPEED_MAX  = 33'h0FFFFFFF;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 33'sh040000000;

  localparam logic [2:0] REG_DEST_X   = 3'd0;
  localparam logic [2:0] REG_DEST_Y   = 3'd1;
  localparam logic [2:0] REG_STOP_RAD = 3'd2;
  localparam logic [2:0] REG_ALIGN    = 3'd3;
  localparam logic [2:0] REG_SETTLE   = 3'd4;
  localparam logic [2:0] REG_GAIN     = 3'd5;

  localparam logic [31:0] ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] heading;
  } in_t;

  typedef struct packed {
    logic [27:0]        forward_speed;
    logic signed [15:0] turn_command;
  } out_t;

  typedef struct packed {
    logic                   vld;
    logic signed [CW-1:0]   x;
    logic signed [CW-1:0]   y;
    logic signed [ZW-1:0]   z;
  } cord_t;

endpackage

/* rtl/core/ggh_cordic_cell.sv */
// One vectoring rotation of the arctangent chain, registered.
// Depends on ggh_pkg for the beat type and the angle table.
module ggh_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ggh_pkg::cord_t din,
  output ggh_pkg::cord_t dout
);

  ggh_pkg::cord_t dout_r, dout_nxt;
  logic signed [ggh_pkg::CW-1:0] xs, ys;
  logic signed [ggh_pkg::ZW-1:0] da;

  always_comb begin
    xs = din.x >>> STEP;
    ys = din.y >>> STEP;
    da = $signed({1'b0, ggh_pkg::ATAN_TAB[STEP]});
    dout_nxt.vld = din.vld;
    if (din.y >= 0) begin
      dout_nxt.x = din.x + ys;
      dout_nxt.y = din.y - xs;
      dout_nxt.z = din.z + da;
    end else begin
      dout_nxt.x = din.x - ys;
      dout_nxt.y = din.y + xs;
      dout_nxt.z = din.z - da;
    end
  end

  always_ff @(posedge clk) begin
    dout_r.x <= dout_nxt.x;
    dout_r.y <= dout_nxt.y;
    dout_r.z <= dout_nxt.z;
    if (!rst_n) begin
      dout_r.vld <= 1'b0;
    end else begin
      dout_r.vld <= dout_nxt.vld;
    end
  end

  assign dout = dout_r;

endmodule

/* rtl/core/ggh_isqrt.sv */
// Integer square root, floor, one result bit per cycle.
// Depends on ggh_pkg for the step count.
module ggh_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [49:0] n,
  output logic        done,
  output logic [24:0] root
);

  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [49:0] rem_r, rem_nxt, r_r, r_nxt, bitv, t;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    pos_nxt  = pos_r;
    rem_nxt  = rem_r;
    r_nxt    = r_r;
    bitv     = 50'(1) << {pos_r, 1'b0};
    t        = r_r + bitv;
    if (start) begin
      busy_nxt = 1'b1;
      pos_nxt  = 5'(ggh_pkg::ROOT_STEPS - 1);
      rem_nxt  = n;
      r_nxt    = '0;
    end else if (busy_r) begin
      if (rem_r >= t) begin
        rem_nxt = rem_r - t;
        r_nxt   = (r_r >> 1) + bitv;
      end else begin
        r_nxt = r_r >> 1;
      end
      pos_nxt = pos_r - 5'd1;
      if (pos_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    rem_r <= rem_nxt;
    r_r   <= r_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = r_r[24:0];

endmodule

/* rtl/core/go_to_goal_heading_controller.sv */
// Go-to-goal heading controller: one result per accepted position beat.
// The result waits for the 25-step square root and for the arctangent chain of
// CORDIC_STEPS cells, which runs alongside it.
// One beat is in flight at a time: a new beat is accepted only when idle and the last result has been taken.
// Synchronous active-low reset clears control state and loads register defaults.
// Depends on ggh_pkg, ggh_cordic_cell and ggh_isqrt.
module go_to_goal_heading_controller #(
  parameter int CORDIC_STEPS  = ggh_pkg::CORDIC_STEPS_DEF,
  parameter int POS_FRAC_BITS = ggh_pkg::POS_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ggh_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ggh_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [23:0]   cfg_data
);

  localparam int SR_RESET = ((3 << POS_FRAC_BITS) + 5) / 10;

  typedef enum logic [2:0] {S_IDLE, S_SQ, S_SUM, S_WAIT, S_CONV, S_DEC} state_t;
  state_t state_r;

  logic signed [23:0] dest_x_r, dest_y_r;
  logic [15:0] stop_r;
  logic [13:0] align_r, settle_r;
  logic [7:0]  gain_r;
  logic signed [15:0] held_r;

  logic signed [24:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic [24:0] ax_r, ay_r;
  logic signed [15:0] hd_r;
  logic [49:0] sqx_r, sqy_r;
  logic [24:0] dist_r;
  logic        dist_ok_r, z_ok_r;
  logic signed [ggh_pkg::ZW-1:0] z_r;
  logic [13:0] atd_r;
  logic [32:0] spd_r;
  logic signed [14:0] h_r;
  logic        out_valid_r;
  ggh_pkg::out_t out_r;

  ggh_pkg::cord_t chain [CORDIC_STEPS+1];
  logic        sq_start, sq_done;
  logic [24:0] sq_root;

  logic signed [21:0] hmul;
  logic [30:0] zc;
  logic [36:0] zmul;
  logic signed [17:0] at, err;
  logic [17:0] aerr;
  logic [27:0] spd_sat;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE) || out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign sq_start  = (state_r == S_SUM);

  assign dx_nxt = 25'(dest_x_r) - 25'(in_data.pos_x);
  assign dy_nxt = 25'(dest_y_r) - 25'(in_data.pos_y);

  always_comb begin
    chain[0].vld = (state_r == S_SQ);
    chain[0].x   = $signed({3'b0, ax_r, 24'b0});
    chain[0].y   = $signed({3'b0, ay_r, 24'b0});
    chain[0].z   = '0;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    ggh_cordic_cell #(.STEP(g)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  ggh_isqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .n    (sqx_r + sqy_r),
    .done (sq_done),
    .root (sq_root)
  );

  always_comb begin
    hmul = 22'(hd_r) * 22'sd45 + 22'sd64;
    if (z_r < 0) begin
      zc = '0;
    end else if (z_r > ggh_pkg::QUARTER_TURN) begin
      zc = 31'(ggh_pkg::QUARTER_TURN);
    end else begin
      zc = z_r[30:0];
    end
    zmul = 37'(zc) * 37'd45 + 37'(1 << 22);

    if (dx_r == 0) begin
      at = (dy_r > 0) ? ggh_pkg::DEG90 : ((dy_r < 0) ? -ggh_pkg::DEG90 : 18'sd0);
    end else if (dy_r != 0 && ((dx_r > 0) == (dy_r > 0))) begin
      at = -$signed({4'b0, atd_r});
    end else begin
      at = $signed({4'b0, atd_r});
    end
    err = 18'(h_r) + at;
    if (dx_r > 0) begin
      err = (hd_r < 0) ? err + ggh_pkg::DEG180 : err - ggh_pkg::DEG180;
    end
    if (err > ggh_pkg::TURN_LIMIT) begin
      err = ggh_pkg::TURN_LIMIT;
    end else if (err < -ggh_pkg::TURN_LIMIT) begin
      err = -ggh_pkg::TURN_LIMIT;
    end
    aerr = (err < 0) ? 18'(-err) : 18'(err);
    spd_sat = (spd_r > ggh_pkg::SPEED_MAX) ? 28'h0FFFFFFF : spd_r[27:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dest_x_r    <= '0;
      dest_y_r    <= '0;
      stop_r      <= 16'(SR_RESET);
      align_r     <= 14'd192;
      settle_r    <= 14'd64;
      gain_r      <= 8'd10;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      dist_ok_r   <= 1'b0;
      z_ok_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          ggh_pkg::REG_DEST_X:   dest_x_r <= $signed(cfg_data);
          ggh_pkg::REG_DEST_Y:   dest_y_r <= $signed(cfg_data);
          ggh_pkg::REG_STOP_RAD: stop_r   <= cfg_data[15:0];
          ggh_pkg::REG_ALIGN:    align_r  <= cfg_data[13:0];
          ggh_pkg::REG_SETTLE:   settle_r <= cfg_data[13:0];
          ggh_pkg::REG_GAIN:     gain_r   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (sq_done) begin
        dist_r    <= sq_root;
        dist_ok_r <= 1'b1;
      end
      if (chain[CORDIC_STEPS].vld) begin
        z_r    <= chain[CORDIC_STEPS].z;
        z_ok_r <= 1'b1;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            dx_r    <= dx_nxt;
            dy_r    <= dy_nxt;
            ax_r    <= (dx_nxt < 0) ? 25'(-dx_nxt) : 25'(dx_nxt);
            ay_r    <= (dy_nxt < 0) ? 25'(-dy_nxt) : 25'(dy_nxt);
            hd_r    <= in_data.heading;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sqx_r     <= 50'(ax_r) * 50'(ax_r);
          sqy_r     <= 50'(ay_r) * 50'(ay_r);
          dist_ok_r <= 1'b0;
          z_ok_r    <= 1'b0;
          state_r   <= S_SUM;
        end
        S_SUM: state_r <= S_WAIT;
        S_WAIT: begin
          if (dist_ok_r && z_ok_r) begin
            state_r <= S_CONV;
          end
        end
        S_CONV: begin
          atd_r   <= zmul[36:23];
          spd_r   <= 33'(dist_r) * 33'(gain_r);
          h_r     <= 15'(hmul >>> 7);
          state_r <= S_DEC;
        end
        S_DEC: begin
          out_valid_r <= 1'b1;
          if (dist_r < 25'(stop_r)) begin
            held_r     <= '0;
            out_r      <= '0;
          end else if (aerr < 18'(align_r)) begin
            out_r.forward_speed <= spd_sat;
            if (aerr < 18'(settle_r)) begin
              held_r             <= '0;
              out_r.turn_command <= '0;
            end else begin
              out_r.turn_command <= held_r;
            end
          end else begin
            held_r              <= 16'(err);
            out_r.forward_speed <= '0;
            out_r.turn_command  <= 16'(err);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
